@@ hw/rtl/pte_pkg.sv @@
// shared constants and types for the packet timestamp estimator
`default_nettype none

package pte_pkg;

   // divider sizing: widest dividend is the 88-bit scaled cycle difference
   localparam int unsigned DIVIDEND_W = 88;
   localparam int unsigned DIVISOR_W  = 64;
   localparam int unsigned QUOTIENT_W = 64;
   localparam int unsigned STEPS_W    = 7;
   localparam int unsigned WORD_W     = 32;

   localparam logic [STEPS_W-1:0] STEPS_PRECISE = STEPS_W'(DIVIDEND_W);
   localparam logic [STEPS_W-1:0] STEPS_WORD    = STEPS_W'(WORD_W);

   // ticks to 100 ns units
   localparam int unsigned SCALE_W = 24;
   localparam logic [SCALE_W-1:0] UNIT_SCALE = 24'd10000000;

   localparam int unsigned RATE_W = 34;
   localparam logic [31:0] SPEED_RESET = 32'd1250;

   // register map
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] REG_TICK_RATE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_CYCLES = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_TIME   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RECAL       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OVERHEAD    = 3'd4;

   localparam logic [RATE_W-1:0] TICK_RATE_RESET = 34'd1000000000;
   localparam logic [15:0]       RECAL_RESET     = 16'd1000;
   localparam logic [7:0]        OVERHEAD_RESET  = 8'd24;

   // command codes
   localparam logic CMD_STAMP  = 1'b0;
   localparam logic CMD_RESYNC = 1'b1;

   typedef struct packed {
      logic               start;
      logic [STEPS_W-1:0] steps;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

@@ hw/rtl/packet_timestamp_estimator.sv @@
// packet timestamp estimator top level: sequencer, state and output register
//
// Input channel req_*: one transfer per packet (command 0) or resync (command 1),
// carrying the packet length and the current free-running cycle count.
// Result channel rsp_*: exactly one timestamp transfer per input transfer, in order.
// Configuration csr_*: single-cycle writes; the user must make them only while
// the block is idle, which the block itself does not enforce. A plain stamp
// passes through S_ST_GO, S_ST_WAIT and S_DONE before rsp_valid rises; one shared
// bit-serial divider produces the 32-bit quotient bytes / speed, one bit a cycle.
// A resync builds a 64 x 24 product from two 32 x 24 partial products, then runs
// 88 divider steps by the tick rate. A recalibrating packet (every recal_period
// packets) runs estimate, precise time, new speed and stamp back to back on the
// divider. req_ready is high only while the sequencer is idle; one item is in
// work at a time, and the earliest next transfer comes in the same cycle that rsp_valid rises.
// The result sits in an output register, so the next item is taken while a
// finished timestamp still waits on a stalled receiver; the sequencer holds its
// next result until that register frees up.
// Reset (synchronous) restores the register defaults, clears last time, call
// count and byte count, and sets the speed estimate to 1250.
`default_nettype none

module packet_timestamp_estimator
   import pte_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_command,
   input  wire logic [15:0]           req_packet_length,
   input  wire logic [63:0]           req_cycle_count,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [63:0]                rsp_timestamp,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_EST_GO   = 4'd1;
   localparam logic [3:0] S_EST_WAIT = 4'd2;
   localparam logic [3:0] S_DIFF     = 4'd3;
   localparam logic [3:0] S_MUL_LO   = 4'd4;
   localparam logic [3:0] S_MUL_HI   = 4'd5;
   localparam logic [3:0] S_PT_GO    = 4'd6;
   localparam logic [3:0] S_PT_WAIT  = 4'd7;
   localparam logic [3:0] S_RECAL    = 4'd8;
   localparam logic [3:0] S_SPD_GO   = 4'd9;
   localparam logic [3:0] S_SPD_WAIT = 4'd10;
   localparam logic [3:0] S_ST_GO    = 4'd11;
   localparam logic [3:0] S_ST_WAIT  = 4'd12;
   localparam logic [3:0] S_DONE     = 4'd13;

   // configuration
   logic [RATE_W-1:0] tick_rate_ff, tick_rate_in;
   logic [63:0]       base_cycles_ff, base_cycles_in;
   logic [63:0]       base_time_ff, base_time_in;
   logic [15:0]       recal_ff, recal_in;
   logic [7:0]        overhead_ff, overhead_in;

   // estimator state
   logic [3:0]  state_ff, state_in;
   logic [63:0] last_time_ff, last_time_in;
   logic [15:0] call_ff, call_in;
   logic [31:0] byte_total_ff, byte_total_in;
   logic [31:0] speed_ff, speed_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // per-item working registers
   logic                  cmd_ff, cmd_in;
   logic [15:0]           len_ff, len_in;
   logic [63:0]           cyc_ff, cyc_in;
   logic [63:0]           diff_ff, diff_in;
   logic [DIVIDEND_W-1:0] prod_ff, prod_in;
   logic [63:0]           est_ff, est_in;
   logic [63:0]           now_ff, now_in;
   logic [63:0]           elapsed_ff, elapsed_in;
   logic [63:0]           result_ff, result_in;
   logic [63:0]           rsp_ts_ff, rsp_ts_in;

   logic                        accept;
   logic                        out_free;
   logic [31:0]                 mul_a;
   logic [31+SCALE_W:0]         mul_p;
   logic [RATE_W-1:0]           rate_nz;
   logic [31:0]                 speed_nz;
   logic [63:0]                 now_calc;
   logic [63:0]                 elapsed_calc;
   logic [31:0]                 quo_word;
   logic [31:0]                 pkt_bytes;

   div_ctl_type           div_ctl;
   div_stat_type          div_stat;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic [QUOTIENT_W-1:0] div_quo;

   pte_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   assign req_ready     = (state_ff == S_IDLE);
   assign accept        = req_valid && req_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_timestamp = rsp_ts_ff;
   assign out_free      = !rsp_valid_ff || rsp_ready;

   assign rate_nz  = (tick_rate_ff == '0) ? RATE_W'(1) : tick_rate_ff;
   assign speed_nz = (speed_ff == '0) ? 32'd1 : speed_ff;
   assign quo_word = div_quo[31:0];

   // one 32 x 24 multiplier shared by both halves of the cycle difference
   assign mul_a = (state_ff == S_MUL_HI) ? diff_ff[63:32] : diff_ff[31:0];
   assign mul_p = mul_a * UNIT_SCALE;

   assign now_calc     = div_quo + base_time_ff;
   assign elapsed_calc = now_ff - last_time_ff;
   assign pkt_bytes    = {16'd0, len_ff} + {24'd0, overhead_ff};

   // divider operand select
   always_comb begin
      div_ctl.start = 1'b0;
      div_ctl.steps = STEPS_WORD;
      div_dividend  = {byte_total_ff, (DIVIDEND_W - WORD_W)'(0)};
      div_divisor   = {32'd0, speed_nz};
      unique case (state_ff)
         S_EST_GO, S_ST_GO: begin
            div_ctl.start = 1'b1;
         end
         S_PT_GO: begin
            div_ctl.start = 1'b1;
            div_ctl.steps = STEPS_PRECISE;
            div_dividend  = prod_ff;
            div_divisor   = {(DIVISOR_W - RATE_W)'(0), rate_nz};
         end
         S_SPD_GO: begin
            div_ctl.start = 1'b1;
            div_divisor   = elapsed_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      tick_rate_in   = tick_rate_ff;
      base_cycles_in = base_cycles_ff;
      base_time_in   = base_time_ff;
      recal_in       = recal_ff;
      overhead_in    = overhead_ff;
      state_in       = state_ff;
      last_time_in   = last_time_ff;
      call_in        = call_ff;
      byte_total_in  = byte_total_ff;
      speed_in       = speed_ff;
      rsp_valid_in   = rsp_valid_ff;
      cmd_in         = cmd_ff;
      len_in         = len_ff;
      cyc_in         = cyc_ff;
      diff_in        = diff_ff;
      prod_in        = prod_ff;
      est_in         = est_ff;
      now_in         = now_ff;
      elapsed_in     = elapsed_ff;
      result_in      = result_ff;
      rsp_ts_in      = rsp_ts_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write_en) begin
         unique case (csr_index)
            REG_TICK_RATE:   tick_rate_in   = csr_wdata[RATE_W-1:0];
            REG_BASE_CYCLES: base_cycles_in = csr_wdata;
            REG_BASE_TIME:   base_time_in   = csr_wdata;
            REG_RECAL:       recal_in       = csr_wdata[15:0];
            REG_OVERHEAD:    overhead_in    = csr_wdata[7:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in = req_command;
               len_in = req_packet_length;
               cyc_in = req_cycle_count;
               if (req_command == CMD_RESYNC) begin
                  state_in = S_DIFF;
               end else if (call_ff == recal_ff) begin
                  state_in = S_EST_GO;
               end else begin
                  call_in       = call_ff + 16'd1;
                  byte_total_in = byte_total_ff + {16'd0, req_packet_length}
                                  + {24'd0, overhead_ff};
                  state_in      = S_ST_GO;
               end
            end
         end
         S_EST_GO: state_in = S_EST_WAIT;
         S_EST_WAIT: begin
            if (div_stat.done) begin
               est_in   = last_time_ff + {32'd0, quo_word};
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            diff_in  = cyc_ff - base_cycles_ff;
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            prod_in  = {(DIVIDEND_W - 32 - SCALE_W)'(0), mul_p};
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            prod_in  = prod_ff + {mul_p, 32'd0};
            state_in = S_PT_GO;
         end
         S_PT_GO: state_in = S_PT_WAIT;
         S_PT_WAIT: begin
            if (div_stat.done) begin
               if (cmd_ff == CMD_RESYNC) begin
                  last_time_in = now_calc;
                  result_in    = now_calc;
                  state_in     = S_DONE;
               end else begin
                  now_in   = now_calc;
                  state_in = S_RECAL;
               end
            end
         end
         S_RECAL: begin
            // estimate fell behind: adopt the precise time
            if (est_ff < now_ff) begin
               last_time_in = now_ff;
            end
            elapsed_in = (elapsed_calc == '0) ? 64'd1 : elapsed_calc;
            call_in    = 16'd1;
            state_in   = S_SPD_GO;
         end
         S_SPD_GO: state_in = S_SPD_WAIT;
         S_SPD_WAIT: begin
            if (div_stat.done) begin
               speed_in      = (quo_word == '0) ? 32'd1 : quo_word;
               byte_total_in = pkt_bytes;
               state_in      = S_ST_GO;
            end
         end
         S_ST_GO: state_in = S_ST_WAIT;
         S_ST_WAIT: begin
            if (div_stat.done) begin
               result_in = last_time_ff + {32'd0, quo_word};
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ts_in    = result_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff   <= TICK_RATE_RESET;
         base_cycles_ff <= '0;
         base_time_ff   <= '0;
         recal_ff       <= RECAL_RESET;
         overhead_ff    <= OVERHEAD_RESET;
         state_ff       <= S_IDLE;
         last_time_ff   <= '0;
         call_ff        <= '0;
         byte_total_ff  <= '0;
         speed_ff       <= SPEED_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         tick_rate_ff   <= tick_rate_in;
         base_cycles_ff <= base_cycles_in;
         base_time_ff   <= base_time_in;
         recal_ff       <= recal_in;
         overhead_ff    <= overhead_in;
         state_ff       <= state_in;
         last_time_ff   <= last_time_in;
         call_ff        <= call_in;
         byte_total_ff  <= byte_total_in;
         speed_ff       <= speed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      len_ff     <= len_in;
      cyc_ff     <= cyc_in;
      diff_ff    <= diff_in;
      prod_ff    <= prod_in;
      est_ff     <= est_in;
      now_ff     <= now_in;
      elapsed_ff <= elapsed_in;
      result_ff  <= result_in;
      rsp_ts_ff  <= rsp_ts_in;
   end

`ifndef NO_ASSERTIONS
   a_speed_nonzero: assert property (@(posedge clock) disable iff (reset)
      speed_ff != 32'd0)
      else $error("speed estimate reached zero");

   a_wait_has_divider: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EST_WAIT || state_ff == S_PT_WAIT || state_ff == S_SPD_WAIT
       || state_ff == S_ST_WAIT) |-> (div_stat.busy || div_stat.done))
      else $error("sequencer waits on an idle divider");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> (rsp_valid_ff && rsp_ts_ff == $past(result_ff)))
      else $error("finished result not moved to the output register");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/pte_divider.sv @@
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module pte_divider
   import pte_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire div_ctl_type           ctl,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output div_stat_type               stat,
   output logic [QUOTIENT_W-1:0]      quotient
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEPS_W-1:0]    cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] num_ff, num_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [QUOTIENT_W-1:0] quo_ff, quo_in;

   logic [DIVISOR_W:0] rem_sh;
   logic [DIVISOR_W:0] rem_sub;
   logic               ge;

   // dividend is consumed msb first
   assign rem_sh  = {rem_ff, num_ff[DIVIDEND_W-1]};
   assign ge      = rem_sh >= {1'b0, div_ff};
   assign rem_sub = rem_sh - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = ctl.steps;
         num_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
         quo_in = {quo_ff[QUOTIENT_W-2:0], ge};
         num_in = {num_ff[DIVIDEND_W-2:0], 1'b0};
         cnt_in = cnt_ff - STEPS_W'(1);
         if (cnt_ff == STEPS_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

`ifndef NO_ASSERTIONS
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !ctl.start && cnt_ff == STEPS_W'(1)) |=> (done_ff && !busy_ff))
      else $error("divider did not finish after its last step");

   a_done_needs_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a run");
`endif

endmodule

`default_nettype wire

@@ sim/packet_timestamp_estimator_tb.sv @@
// self-checking testbench for the packet timestamp estimator
`timescale 1ns / 100ps

module packet_timestamp_estimator_tb;
   import pte_pkg::*;

   localparam int unsigned LIMIT_CYCLES  = 2000000;
   localparam int unsigned SETTLE_CYCLES = 250;
   localparam logic [63:0] ALL_ONES      = '1;

   logic                  clock             = 1'b0;
   logic                  reset             = 1'b1;
   logic                  req_valid         = 1'b0;
   logic                  req_ready;
   logic                  req_command       = CMD_STAMP;
   logic [15:0]           req_packet_length = '0;
   logic [63:0]           req_cycle_count   = '0;
   logic                  rsp_valid;
   logic                  rsp_ready         = 1'b0;
   logic [63:0]           rsp_timestamp;
   logic                  csr_write_en      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index         = REG_TICK_RATE;
   logic [CSR_DATA_W-1:0] csr_wdata         = '0;

   // shadow registers and estimator state
   logic [RATE_W-1:0] cfg_tick_rate;
   logic [63:0]       cfg_base_cycles;
   logic [63:0]       cfg_base_time;
   logic [15:0]       cfg_recal_period;
   logic [7:0]        cfg_overhead;
   logic [63:0]       est_last_time;
   logic [15:0]       est_call_count;
   logic [31:0]       est_byte_total;
   logic [31:0]       est_speed;

   logic [63:0] expected_stamps[$];
   logic [63:0] want_stamp;
   logic [63:0] cycle_now;
   int          mismatch_count = 0;
   int unsigned cycle_total    = 0;
   int          send_idle_pct  = 18;
   int          recv_idle_pct  = 79;

   packet_timestamp_estimator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_packet_length(req_packet_length),
      .req_cycle_count  (req_cycle_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_timestamp    (rsp_timestamp),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_total++;
      if (cycle_total >= LIMIT_CYCLES) begin
         $display("%0t ns: timeout", $time);
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_stamps.size() == 0) begin
            $display("%0t ns: unexpected timestamp, expected none, actual %h",
                     $time, rsp_timestamp);
            mismatch_count++;
         end else begin
            want_stamp = expected_stamps.pop_front();
            if (rsp_timestamp !== want_stamp) begin
               $display("%0t ns: timestamp mismatch, expected %h, actual %h",
                        $time, want_stamp, rsp_timestamp);
               mismatch_count++;
            end
         end
      end
   end

   // (cycles - base) * 10^7 / rate + base, product kept exact at 88 bits
   function automatic logic [63:0] wall_time_at(input logic [63:0] cyc);
      logic [63:0] diff;
      logic [87:0] product;
      logic [87:0] divisor;
      logic [87:0] quotient;
      diff     = cyc - cfg_base_cycles;
      product  = {24'd0, diff} * 88'd10000000;
      divisor  = (cfg_tick_rate == '0) ? 88'd1 : {54'd0, cfg_tick_rate};
      quotient = product / divisor;
      return quotient[63:0] + cfg_base_time;
   endfunction

   function automatic logic [63:0] predict_timestamp(input logic cmd,
                                                     input logic [15:0] len,
                                                     input logic [63:0] cyc);
      logic [63:0] old_time;
      logic [63:0] estimate;
      logic [63:0] wall;
      logic [63:0] elapsed;
      logic [63:0] quot;
      if (cmd == CMD_RESYNC) begin
         est_last_time = wall_time_at(cyc);
         return est_last_time;
      end
      if (est_call_count == cfg_recal_period) begin
         old_time = est_last_time;
         estimate = est_last_time + {32'd0, est_byte_total / est_speed};
         wall     = wall_time_at(cyc);
         est_call_count = 16'd1;
         if (estimate < wall)
            est_last_time = wall;
         elapsed = wall - old_time;
         if (elapsed == '0)
            elapsed = 64'd1;
         quot      = {32'd0, est_byte_total} / elapsed;
         est_speed = (quot[31:0] == '0) ? 32'd1 : quot[31:0];
         est_byte_total = '0;
      end else begin
         est_call_count = est_call_count + 16'd1;
      end
      est_byte_total = est_byte_total + {16'd0, len} + {24'd0, cfg_overhead};
      return est_last_time + {32'd0, est_byte_total / est_speed};
   endfunction

   task automatic send_request(input logic cmd, input logic [15:0] len,
                               input logic [63:0] cyc);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_packet_length <= len;
      req_cycle_count   <= cyc;
      do @(posedge clock); while (!req_ready);
      expected_stamps.push_back(predict_timestamp(cmd, len, cyc));
   endtask

   // always waits on a clock edge so valid never drops and rises in one step
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_stamps.size() != 0 || !req_ready);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      case (idx)
         REG_TICK_RATE:   cfg_tick_rate    = data[RATE_W-1:0];
         REG_BASE_CYCLES: cfg_base_cycles  = data;
         REG_BASE_TIME:   cfg_base_time    = data;
         REG_RECAL:       cfg_recal_period = data[15:0];
         REG_OVERHEAD:    cfg_overhead     = data[7:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [63:0] rate, input logic [63:0] base_cyc,
                             input logic [63:0] base_tm, input logic [63:0] period,
                             input logic [63:0] overhead);
      drain_results();
      write_reg(REG_TICK_RATE, rate);
      write_reg(REG_BASE_CYCLES, base_cyc);
      write_reg(REG_BASE_TIME, base_tm);
      write_reg(REG_RECAL, period);
      write_reg(REG_OVERHEAD, overhead);
      csr_write_en <= 1'b0;
   endtask

   // the call counter is still zero here, so a zero period recalibrates at once
   task automatic test_zero_period();
      send_request(CMD_RESYNC, 16'hFFFF, 64'd0);
      send_request(CMD_RESYNC, 16'd0, ALL_ONES);
      drain_results();
      write_reg(REG_RECAL, 64'd0);
      csr_write_en <= 1'b0;
      // same cycle count as the resync: no elapsed time, speed drops to one
      send_request(CMD_STAMP, 16'hFFFF, ALL_ONES);
      send_request(CMD_STAMP, 16'd0, ALL_ONES);
   endtask

   task automatic test_register_extremes();
      set_config(64'd0, ALL_ONES, ALL_ONES, 64'(est_call_count) + 64'd1, 64'd255);
      send_request(CMD_RESYNC, 16'd0, 64'd0);
      send_request(CMD_STAMP, 16'h8000, 64'd5);
      send_request(CMD_STAMP, 16'hFFFF, ALL_ONES);
      // upper data bits beyond each register must be dropped
      set_config(ALL_ONES, 64'd0, 64'd0, ALL_ONES, {56'hFFFF_FFFF_FFFF_FF, 8'd0});
      send_request(CMD_STAMP, 16'hFFFF, ALL_ONES);
      send_request(CMD_RESYNC, 16'd0, ALL_ONES);
      send_request(CMD_STAMP, 16'd0, 64'd0);
   endtask

   task automatic test_recalibration();
      // one cycle per 100 ns unit keeps the arithmetic readable
      set_config(64'd10000000, 64'd1000, 64'd5000, 64'(est_call_count) + 64'd1, 64'd24);
      cycle_now = 64'd100000;
      repeat (7) begin
         cycle_now = cycle_now + 64'd300;
         send_request(CMD_STAMP, 16'd1500, cycle_now);
      end
      send_request(CMD_RESYNC, 16'd0, cycle_now);
      // counter moved backward: elapsed time wraps
      repeat (4) begin
         cycle_now = cycle_now - 64'd20000;
         send_request(CMD_STAMP, 16'd64, cycle_now);
      end
   endtask

   task automatic test_random_traffic(input int sender_idle, input int receiver_idle,
                                      input int items);
      int          setting;
      int          n;
      int          period;
      logic        cmd;
      logic [15:0] len;
      logic [63:0] rate_word;
      logic [63:0] base_cyc;
      logic [63:0] base_tm;
      send_idle_pct = sender_idle;
      recv_idle_pct = receiver_idle;
      for (setting = 0; setting < 2; setting++) begin
         case ($urandom_range(0, 7))
            0:       rate_word = 64'd0;
            1:       rate_word = ALL_ONES;
            2:       rate_word = {$urandom, $urandom};
            default: rate_word = 64'($urandom_range(1000000, 1000000000));
         endcase
         if ($urandom_range(0, 3) == 0)
            base_cyc = {$urandom, $urandom};
         else
            base_cyc = cycle_now - 64'($urandom_range(0, 100000));
         base_tm = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : 64'($urandom);
         // keep the period at or above the counter so recalibration still comes
         if ($urandom_range(0, 9) == 0)
            period = 65535;
         else
            period = int'(est_call_count) + $urandom_range(0, 12);
         if (period > 65535)
            period = 65535;
         set_config(rate_word, base_cyc, base_tm,
                    {$urandom, 16'($urandom), 16'(period)}, {$urandom, $urandom});
         for (n = 0; n < items / 2; n++) begin
            if ($urandom_range(0, 59) == 0)
               drain_results();
            cmd = ($urandom_range(0, 9) == 0) ? CMD_RESYNC : CMD_STAMP;
            case ($urandom_range(0, 15))
               0:       len = 16'd0;
               1:       len = 16'hFFFF;
               default: len = 16'($urandom);
            endcase
            case ($urandom_range(0, 19))
               0:       cycle_now = {$urandom, $urandom};
               1:       cycle_now = cycle_now - 64'($urandom_range(0, 50000));
               default: cycle_now = cycle_now + 64'($urandom_range(0, 20000));
            endcase
            send_request(cmd, len, cycle_now);
         end
      end
   endtask

   initial begin
      cfg_tick_rate    = TICK_RATE_RESET;
      cfg_base_cycles  = '0;
      cfg_base_time    = '0;
      cfg_recal_period = RECAL_RESET;
      cfg_overhead     = OVERHEAD_RESET;
      est_last_time    = '0;
      est_call_count   = '0;
      est_byte_total   = '0;
      est_speed        = SPEED_RESET;
      cycle_now        = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_zero_period();
      test_register_extremes();
      test_recalibration();
      test_random_traffic(18, 79, 400);
      test_random_traffic(79, 18, 400);
      test_random_traffic(0, 0, 400);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_stamps.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
